// File: hw/rtl/cpffm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpffm_pkg
// Types and codes shared by the clock page-fault frame manager modules.
// ----------------------------------------------------------------------------
package cpffm_pkg;

    localparam int PAGE_NUM_W  = 6;
    localparam int PROC_W      = 8;
    localparam int FRAME_RES_W = 4;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAULT = 2'd2;

    localparam logic REQ_REF   = 1'b0;
    localparam logic REQ_FAULT = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [PAGE_NUM_W-1:0] page_number;
        logic                  is_write;
        logic [PROC_W-1:0]     proc_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [FRAME_RES_W-1:0] frame;
        logic                   evicted;
        logic [PAGE_NUM_W-1:0]  victim_page;
        logic [PROC_W-1:0]      victim_proc;
        logic                   writeback;
    } rsp_t;

    // page table read port source
    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_REQ    = 2'd1,
        RD_SWEEP  = 2'd2,
        RD_VICTIM = 2'd3
    } rd_sel_t;

    // page table write port operation
    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_CLEAR    = 3'd1,
        WR_REF      = 3'd2,
        WR_USED_CLR = 3'd3,
        WR_UNMAP    = 3'd4,
        WR_MAP      = 3'd5
    } wr_sel_t;

    typedef enum logic [1:0] {
        PICK_NONE = 2'd0,
        PICK_SCAN = 2'd1,
        PICK_CHK  = 2'd2,
        PICK_ZERO = 2'd3
    } pick_t;

    typedef enum logic [2:0] {
        RES_NONE      = 3'd0,
        RES_HIT       = 3'd1,
        RES_NOMAP     = 3'd2,
        RES_FAULT_OLD = 3'd3,
        RES_FAULT_NEW = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic     load;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        logic     count;
        logic     scan_init;
        logic     scan_step;
        logic     sweep_init;
        logic     sweep_run;
        pick_t    pick;
        logic     cap_victim;
        logic     set_evict;
        logic     map_frame;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic req_type;
        logic entry_valid;
        logic scan_free;
        logic scan_last;
        logic chk_vld;
        logic chk_used;
        logic visit_last;
    } stat_t;

endpackage

// File: hw/rtl/cpffm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpffm_dp
// Datapath: page table memory, frame table, sweep pointers, result register.
// ----------------------------------------------------------------------------
module cpffm_dp
    import cpffm_pkg::*;
#(
    parameter int NUM_FRAMES = 16,
    parameter int NUM_PAGES  = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  cmd_t  cmd,
    output stat_t stat,
    output rsp_t  rsp,
    output logic  done
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int PW = $clog2(NUM_PAGES);
    localparam int VW = $clog2(2 * NUM_FRAMES);
    localparam int EW = FW + 3;

    localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);
    localparam logic [PW-1:0] LAST_PAGE  = PW'(NUM_PAGES - 1);
    localparam logic [VW-1:0] LAST_VISIT = VW'(2 * NUM_FRAMES - 1);

    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic          used;
        logic [FW-1:0] frame;
    } pte_t;

    // wrap the page number into the table by conditional subtracts
    function automatic logic [PW-1:0] wrap_page(input logic [PAGE_NUM_W-1:0] pn);
        logic [PAGE_NUM_W-1:0] v;
        v = pn;
        for (int k = PAGE_NUM_W - 1; k >= 0; k--) begin
            if (int'(v) >= (NUM_PAGES << k))
            begin
                v = v - PAGE_NUM_W'(NUM_PAGES << k);
            end
        end
        return PW'(v);
    endfunction

    function automatic logic [FRAME_RES_W-1:0] frame_res(input logic [FW-1:0] f);
        logic [FW+FRAME_RES_W-1:0] t;
        t = {{FRAME_RES_W{1'b0}}, f};
        return t[FRAME_RES_W-1:0];
    endfunction

    function automatic logic [PAGE_NUM_W-1:0] page_res(input logic [PW-1:0] p);
        logic [PW+PAGE_NUM_W-1:0] t;
        t = {{PAGE_NUM_W{1'b0}}, p};
        return t[PAGE_NUM_W-1:0];
    endfunction

    function automatic logic [FW-1:0] frame_inc(input logic [FW-1:0] f);
        return (f == LAST_FRAME) ? '0 : f + FW'(1);
    endfunction

    // page table memory
    pte_t page_mem [NUM_PAGES];
    pte_t rd_q_reg;

    // frame table payload
    logic [PROC_W-1:0] fo_proc_reg [NUM_FRAMES];
    logic [PW-1:0]     fo_page_reg [NUM_FRAMES];

    req_t                  req_reg,        req_next;
    logic [PW-1:0]         page_reg,       page_next;
    logic [PW-1:0]         clr_cnt_reg,    clr_cnt_next;
    logic [NUM_FRAMES-1:0] busy_reg,       busy_next;
    logic [FW-1:0]         fidx_reg,       fidx_next;
    logic [FW-1:0]         chk_idx_reg,    chk_idx_next;
    logic [PW-1:0]         chk_page_reg,   chk_page_next;
    logic                  chk_vld_reg,    chk_vld_next;
    logic [VW-1:0]         visit_reg,      visit_next;
    logic [FW-1:0]         victim_reg,     victim_next;
    logic [PW-1:0]         vpage_reg,      vpage_next;
    logic [PROC_W-1:0]     vproc_reg,      vproc_next;
    logic                  ev_reg,         ev_next;
    logic                  wb_reg,         wb_next;
    logic [31:0]           fault_count_reg, fault_count_next;
    rsp_t                  rsp_reg,        rsp_next;
    logic                  done_reg,       done_next;

    logic          mem_we;
    logic          mem_re;
    logic [PW-1:0] mem_waddr;
    logic [PW-1:0] mem_raddr;
    pte_t          mem_wdata;
    logic [FW-1:0] fidx_rd;
    logic [PW-1:0] fo_page_rd;

    assign fidx_rd    = (cmd.rd_sel == RD_VICTIM) ? victim_reg : fidx_reg;
    assign fo_page_rd = fo_page_reg[fidx_rd];

    // page table port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = page_reg;
        mem_wdata = '0;
        case (cmd.wr_sel)
            WR_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            WR_REF:
            begin
                mem_we          = 1'b1;
                mem_wdata       = rd_q_reg;
                mem_wdata.used  = 1'b1;
                mem_wdata.dirty = rd_q_reg.dirty | req_reg.is_write;
            end
            WR_USED_CLR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = chk_page_reg;
                mem_wdata      = rd_q_reg;
                mem_wdata.used = 1'b0;
            end
            WR_UNMAP:
            begin
                mem_we    = 1'b1;
                mem_waddr = vpage_reg;
            end
            WR_MAP:
            begin
                mem_we          = 1'b1;
                mem_wdata.valid = 1'b1;
                mem_wdata.frame = victim_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        mem_re    = 1'b0;
        mem_raddr = page_reg;
        case (cmd.rd_sel)
            RD_REQ:
            begin
                mem_re = 1'b1;
            end
            RD_SWEEP, RD_VICTIM:
            begin
                mem_re    = 1'b1;
                mem_raddr = fo_page_rd;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q_reg <= page_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_frame)
        begin
            fo_proc_reg[victim_reg] <= req_reg.proc_id;
            fo_page_reg[victim_reg] <= page_reg;
        end
    end

    always_comb
    begin
        req_next         = req_reg;
        page_next        = page_reg;
        clr_cnt_next     = clr_cnt_reg;
        busy_next        = busy_reg;
        fidx_next        = fidx_reg;
        chk_idx_next     = chk_idx_reg;
        chk_page_next    = chk_page_reg;
        chk_vld_next     = chk_vld_reg;
        visit_next       = visit_reg;
        victim_next      = victim_reg;
        vpage_next       = vpage_reg;
        vproc_next       = vproc_reg;
        ev_next          = ev_reg;
        wb_next          = wb_reg;
        fault_count_next = fault_count_reg;

        if (cmd.load)
        begin
            req_next  = req;
            page_next = wrap_page(req.page_number);
            ev_next   = 1'b0;
            wb_next   = 1'b0;
        end
        if (cmd.wr_sel == WR_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + PW'(1);
        end
        if (cmd.count)
        begin
            fault_count_next = fault_count_reg + 32'd1;
        end
        if (cmd.scan_init)
        begin
            fidx_next = '0;
        end
        if (cmd.scan_step)
        begin
            fidx_next = frame_inc(fidx_reg);
        end
        if (cmd.sweep_init)
        begin
            fidx_next    = '0;
            chk_vld_next = 1'b0;
            visit_next   = '0;
        end
        // read of frame fidx is issued now, its entry is checked next cycle
        if (cmd.sweep_run)
        begin
            fidx_next     = frame_inc(fidx_reg);
            chk_idx_next  = fidx_reg;
            chk_page_next = fo_page_rd;
            chk_vld_next  = 1'b1;
            if (chk_vld_reg)
            begin
                visit_next = visit_reg + VW'(1);
            end
        end
        case (cmd.pick)
            PICK_SCAN: victim_next = fidx_reg;
            PICK_CHK:  victim_next = chk_idx_reg;
            PICK_ZERO: victim_next = '0;
            default:   victim_next = victim_reg;
        endcase
        if (cmd.cap_victim)
        begin
            vpage_next = fo_page_rd;
            vproc_next = fo_proc_reg[victim_reg];
        end
        if (cmd.set_evict)
        begin
            ev_next = 1'b1;
            wb_next = rd_q_reg.dirty;
        end
        if (cmd.map_frame)
        begin
            busy_next[victim_reg] = 1'b1;
        end
    end

    always_comb
    begin
        rsp_next  = '0;
        done_next = 1'b1;
        case (cmd.res_sel)
            RES_HIT:
            begin
                rsp_next.status = ST_HIT;
                rsp_next.frame  = frame_res(rd_q_reg.frame);
            end
            RES_NOMAP:
            begin
                rsp_next.status = ST_NOMAP;
            end
            RES_FAULT_OLD:
            begin
                rsp_next.status = ST_FAULT;
                rsp_next.frame  = frame_res(rd_q_reg.frame);
            end
            RES_FAULT_NEW:
            begin
                rsp_next.status      = ST_FAULT;
                rsp_next.frame       = frame_res(victim_reg);
                rsp_next.evicted     = ev_reg;
                rsp_next.victim_page = ev_reg ? page_res(vpage_reg) : '0;
                rsp_next.victim_proc = ev_reg ? vproc_reg : '0;
                rsp_next.writeback   = ev_reg & wb_reg;
            end
            default:
            begin
                done_next = 1'b0;
                rsp_next  = rsp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg     <= '0;
            busy_reg        <= '0;
            fidx_reg        <= '0;
            chk_vld_reg     <= 1'b0;
            visit_reg       <= '0;
            ev_reg          <= 1'b0;
            wb_reg          <= 1'b0;
            fault_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            clr_cnt_reg     <= clr_cnt_next;
            busy_reg        <= busy_next;
            fidx_reg        <= fidx_next;
            chk_vld_reg     <= chk_vld_next;
            visit_reg       <= visit_next;
            ev_reg          <= ev_next;
            wb_reg          <= wb_next;
            fault_count_reg <= fault_count_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        page_reg     <= page_next;
        chk_idx_reg  <= chk_idx_next;
        chk_page_reg <= chk_page_next;
        victim_reg   <= victim_next;
        vpage_reg    <= vpage_next;
        vproc_reg    <= vproc_next;
        rsp_reg      <= rsp_next;
    end

    assign stat.clr_last    = (clr_cnt_reg == LAST_PAGE);
    assign stat.req_type    = req_reg.req_type;
    assign stat.entry_valid = rd_q_reg.valid;
    assign stat.scan_free   = ~busy_reg[fidx_reg];
    assign stat.scan_last   = (fidx_reg == LAST_FRAME);
    assign stat.chk_vld     = chk_vld_reg;
    assign stat.chk_used    = rd_q_reg.used;
    assign stat.visit_last  = (visit_reg == LAST_VISIT);

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

// File: hw/rtl/cpffm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpffm_ctrl
// Controller: sequences lookup, free-frame scan, second-chance sweep, mapping.
// ----------------------------------------------------------------------------
module cpffm_ctrl
    import cpffm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_LOOK   = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_SWEEP  = 9'b000100000,
        S_EVRD   = 9'b001000000,
        S_EVICT  = 9'b010000000,
        S_MAP    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_sel = WR_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.rd_sel = RD_REQ;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                if (stat.req_type == REQ_REF)
                begin
                    if (stat.entry_valid)
                    begin
                        cmd.wr_sel  = WR_REF;
                        cmd.res_sel = RES_HIT;
                    end
                    else
                    begin
                        cmd.res_sel = RES_NOMAP;
                    end
                end
                else
                begin
                    cmd.count = 1'b1;
                    if (stat.entry_valid)
                    begin
                        cmd.res_sel = RES_FAULT_OLD;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.scan_free)
                begin
                    cmd.pick   = PICK_SCAN;
                    state_next = S_MAP;
                end
                else if (stat.scan_last)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = S_SWEEP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SWEEP:
            begin
                cmd.rd_sel    = RD_SWEEP;
                cmd.sweep_run = 1'b1;
                if (stat.chk_vld)
                begin
                    if (!stat.chk_used)
                    begin
                        cmd.pick   = PICK_CHK;
                        state_next = S_EVRD;
                    end
                    else
                    begin
                        // second chance: clear used and pass over
                        cmd.wr_sel = WR_USED_CLR;
                        if (stat.visit_last)
                        begin
                            cmd.pick   = PICK_ZERO;
                            state_next = S_EVRD;
                        end
                    end
                end
            end
            S_EVRD:
            begin
                cmd.rd_sel     = RD_VICTIM;
                cmd.cap_victim = 1'b1;
                state_next     = S_EVICT;
            end
            S_EVICT:
            begin
                cmd.wr_sel    = WR_UNMAP;
                cmd.set_evict = 1'b1;
                state_next    = S_MAP;
            end
            S_MAP:
            begin
                cmd.wr_sel    = WR_MAP;
                cmd.map_frame = 1'b1;
                cmd.res_sel   = RES_FAULT_NEW;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: hw/rtl/clock_page_fault_frame_manager.sv
// Reference: the entry is read in S_LOOK and the answer picked in S_DECIDE is registered
// as the result strobe. Fault on a free frame: the scan tests frames from 0, one frame a
// cycle, up to the lowest free frame. Fault with eviction: the second-chance sweep through
// the page table memory, one frame per cycle, picks the victim frame.
// One item at a time; start is taken again in the strobe cycle. The result cannot stall.
// After reset the page table is cleared entry by entry with busy high.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_fault_frame_manager
// Page table with reverse frame table and clock (second-chance) replacement.
// ----------------------------------------------------------------------------
module clock_page_fault_frame_manager
    import cpffm_pkg::*;
#(
    parameter int NUM_FRAMES = 16,
    parameter int NUM_PAGES  = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    cmd_t  cmd;
    stat_t stat;

    cpffm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    cpffm_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .NUM_PAGES  (NUM_PAGES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp),
        .done  (done)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make block busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without work in progress");

    a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.writeback) |-> (rsp.evicted && rsp.status == ST_FAULT))
        else $error("writeback without eviction on a fault");

    a_nomap_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_NOMAP) |-> (rsp.frame == '0 && !rsp.evicted))
        else $error("not-mapped answer carries frame or eviction");

endmodule

// File: tb/tb_clock_page_fault_frame_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_page_fault_frame_manager
// Drives references and faults through the start/busy handshake in random
// bursts and checks every result strobe against the answers typed into the
// directed table or a second-chance page table model kept in the bench. A short
// directed table fills all frames and forces evictions, with and without writeback, before the random traffic.
// ----------------------------------------------------------------------------
module tb_clock_page_fault_frame_manager;
    import cpffm_pkg::*;

    localparam int NFRAMES      = 16;
    localparam int NPAGES       = 64;
    localparam int RANDOM_ITEMS = 1650;
    localparam int IDLE_LIMIT   = 600;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        req_t item;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic done;
    rsp_t rsp;

    // page table and reverse frame table as the block should hold them
    logic       pt_valid [NPAGES];
    logic       pt_dirty [NPAGES];
    logic       pt_used  [NPAGES];
    logic [3:0] pt_frame [NPAGES];
    logic       ft_busy  [NFRAMES];
    logic [7:0] ft_proc  [NFRAMES];
    logic [5:0] ft_page  [NFRAMES];
    logic [31:0] faults_served;

    dir_row_t dir_rows[$];
    rsp_t     pending_rsp[$];
    int       taken_count = 0;
    int       errors = 0;
    int       idle_cycles = 0;

    clock_page_fault_frame_manager uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic req_t mk_req(logic rt, int page, logic wr, int pid);
        req_t r;
        r.req_type    = rt;
        r.page_number = page[5:0];
        r.is_write    = wr;
        r.proc_id     = pid[7:0];
        return r;
    endfunction

    function automatic rsp_t mk_rsp(logic [1:0] st, int frame);
        rsp_t r;
        r        = '0;
        r.status = st;
        r.frame  = frame[3:0];
        return r;
    endfunction

    function automatic void add_row(req_t item, bit typed, rsp_t want);
        dir_row_t row;
        row.item  = item;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // Serves one item on the bench copy of the tables; returns the answer.
    function automatic rsp_t serve_request(req_t r);
        rsp_t res;
        int   pg;
        int   f;
        int   j;
        int   i;
        int   vp;
        res = '0;
        pg  = int'(r.page_number);
        if (r.req_type == REQ_REF)
        begin
            if (pt_valid[pg])
            begin
                pt_used[pg] = 1'b1;
                if (r.is_write)
                    pt_dirty[pg] = 1'b1;
                res.status = ST_HIT;
                res.frame  = pt_frame[pg];
            end
            else
                res.status = ST_NOMAP;
            return res;
        end
        faults_served = faults_served + 1;
        res.status = ST_FAULT;
        if (pt_valid[pg])
        begin
            res.frame = pt_frame[pg];
            return res;
        end
        f = -1;
        for (i = 0; i < NFRAMES; i++)
            if (f < 0 && !ft_busy[i])
                f = i;
        if (f < 0)
        begin
            // second chance: sweep from frame 0, clearing used bits on the way
            j = 0;
            for (i = 0; i < 2 * NFRAMES && f < 0; i++)
            begin
                if (!pt_used[ft_page[j]])
                    f = j;
                else
                begin
                    pt_used[ft_page[j]] = 1'b0;
                    j = (j + 1) % NFRAMES;
                end
            end
            if (f < 0)
                f = 0;
        end
        if (ft_busy[f])
        begin
            vp = int'(ft_page[f]);
            res.evicted     = 1'b1;
            res.victim_page = ft_page[f];
            res.victim_proc = ft_proc[f];
            res.writeback   = pt_dirty[vp];
            pt_valid[vp] = 1'b0;
            pt_dirty[vp] = 1'b0;
            pt_used[vp]  = 1'b0;
        end
        pt_valid[pg] = 1'b1;
        pt_dirty[pg] = 1'b0;
        pt_used[pg]  = 1'b0;
        pt_frame[pg] = f[3:0];
        ft_busy[f]   = 1'b1;
        ft_proc[f]   = r.proc_id;
        ft_page[f]   = pg[5:0];
        res.frame    = f[3:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    initial
    begin : table_init
        int i;
        for (i = 0; i < NPAGES; i++)
        begin
            pt_valid[i] = 1'b0;
            pt_dirty[i] = 1'b0;
            pt_used[i]  = 1'b0;
            pt_frame[i] = '0;
        end
        for (i = 0; i < NFRAMES; i++)
        begin
            ft_busy[i] = 1'b0;
            ft_proc[i] = '0;
            ft_page[i] = '0;
        end
        faults_served = '0;
    end

    // Accepted items feed the model; strobed results are checked in order.
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        rsp_t model_rsp;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, got %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("frame", 32'(want.frame), 32'(rsp.frame));
                    check_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
                    check_field("victim_page", 32'(want.victim_page),
                                32'(rsp.victim_page));
                    check_field("victim_proc", 32'(want.victim_proc),
                                32'(rsp.victim_proc));
                    check_field("writeback", 32'(want.writeback), 32'(rsp.writeback));
                end
            end
            if (start && !busy)
            begin
                model_rsp = serve_request(req);
                if (taken_count < dir_rows.size() && dir_rows[taken_count].typed)
                    pending_rsp.push_back(dir_rows[taken_count].want);
                else
                    pending_rsp.push_back(model_rsp);
                taken_count++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_clock_page_fault_frame_manager NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        req_t item;
        int   total;
        int   k;
        int   burst_left;
        int   gap;
        int   hot_base;
        int   page;

        add_row(mk_req(REQ_REF, 5, 1'b0, 3), 1'b1, mk_rsp(ST_NOMAP, 0));
        add_row(mk_req(REQ_FAULT, 0, 1'b0, 0), 1'b1, mk_rsp(ST_FAULT, 0));
        add_row(mk_req(REQ_FAULT, 63, 1'b1, 255), 1'b1, mk_rsp(ST_FAULT, 1));
        add_row(mk_req(REQ_REF, 63, 1'b1, 0), 1'b1, mk_rsp(ST_HIT, 1));
        add_row(mk_req(REQ_REF, 0, 1'b0, 255), 1'b1, mk_rsp(ST_HIT, 0));
        // fault on a page already mapped keeps its frame
        add_row(mk_req(REQ_FAULT, 63, 1'b0, 7), 1'b1, mk_rsp(ST_FAULT, 1));
        for (k = 1; k <= 14; k++)
            add_row(mk_req(REQ_FAULT, k, k[0], 16 + k), 1'b0, '0);
        // all frames busy: sweeps pass over used pages, last one evicts a dirty page
        add_row(mk_req(REQ_FAULT, 40, 1'b0, 200), 1'b0, '0);
        add_row(mk_req(REQ_FAULT, 41, 1'b1, 201), 1'b0, '0);
        add_row(mk_req(REQ_REF, 41, 1'b0, 202), 1'b0, '0);
        add_row(mk_req(REQ_FAULT, 42, 1'b0, 203), 1'b0, '0);

        total      = dir_rows.size() + RANDOM_ITEMS;
        burst_left = 0;
        hot_base   = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < total; k++)
        begin
            if (k < dir_rows.size())
                item = dir_rows[k].item;
            else
            begin
                if (k % 150 == 0)
                    hot_base = $urandom_range(0, NPAGES - 1);
                // mostly a moving working set a bit larger than memory
                if ($urandom_range(0, 99) < 85)
                    page = (hot_base + $urandom_range(0, 19)) % NPAGES;
                else
                    page = $urandom_range(0, NPAGES - 1);
                item = mk_req(($urandom_range(0, 99) < 40) ? REQ_FAULT : REQ_REF, page,
                              1'($urandom_range(0, 1)), int'($urandom_range(0, 255)));
            end
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 8);
            end
            start <= 1'b1;
            req   <= item;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            burst_left--;
        end
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_clock_page_fault_frame_manager OK");
        else
            $display("tb_clock_page_fault_frame_manager NOT OK");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/cpffm_pkg.sv
hw/rtl/cpffm_dp.sv
hw/rtl/cpffm_ctrl.sv
hw/rtl/clock_page_fault_frame_manager.sv
tb/tb_clock_page_fault_frame_manager.sv
